/* sv/tile_line_rasterizer_defines.svh */
// assertion macros for the tile line rasterizer
// bodies expect clk and rst_n in the scope of the module that uses them
`ifndef TILE_LINE_RASTERIZER_DEFINES_SVH
`define TILE_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define TRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/trl_pkg.sv */
// shared types, widths and codes for the tile line rasterizer
// no dependencies
package trl_pkg;

  localparam int X_W         = 7;
  localparam int Y_W         = 12;
  localparam int ERR_W       = 14;
  localparam int COLOR_W     = 2;
  localparam int TILE_SHIFT  = 3;
  localparam int TILE_PIXELS = 1 << TILE_SHIFT;
  localparam int XT_W        = X_W - TILE_SHIFT;
  localparam int YT_W        = Y_W - TILE_SHIFT;
  localparam int TILE_IDX_W  = 13;
  localparam int TILE_FULL_W = 16;
  localparam int TILES_ROW_DEF = 16;

  localparam int SEL_TX_W = 4;
  localparam int SEL_TY_W = 9;
  localparam int SEL_WD_W = 5;
  localparam int SEL_HT_W = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEL_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_TILE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_TILE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_HEIGHT = 3'd4;

  // item functions
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic                active;
    logic [SEL_TX_W-1:0] tile_x;
    logic [SEL_TY_W-1:0] tile_y;
    logic [SEL_WD_W-1:0] width;
    logic [SEL_HT_W-1:0] height;
  } trl_sel_cfg_t;

  // current pixel and generator status
  typedef struct packed {
    logic               active;
    logic               last;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [COLOR_W-1:0] color;
    logic               check;
  } trl_pixel_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [TILE_IDX_W-1:0] tile_index;
    logic [TILE_SHIFT-1:0] in_tile_col;
    logic [TILE_SHIFT-1:0] in_tile_row;
    logic [COLOR_W-1:0]    draw_color;
    logic                  write_enable;
    logic                  last_pixel;
  } trl_result_t;

endpackage

/* sv/trl_ifs.sv */
// channel interfaces: line item input, pixel word output, config writes
// depends on trl_pkg
interface trl_in_if import trl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [X_W-1:0]     start_x;
  logic [Y_W-1:0]     start_y;
  logic [X_W-1:0]     finish_x;
  logic [Y_W-1:0]     finish_y;
  logic [COLOR_W-1:0] pen_color;
  logic               check_selection;

  modport source (output valid, func, start_x, start_y, finish_x, finish_y,
                  pen_color, check_selection, input ready);
  modport sink (input valid, func, start_x, start_y, finish_x, finish_y,
                pen_color, check_selection, output ready);
endinterface

interface trl_out_if import trl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  pixel_valid;
  logic [TILE_IDX_W-1:0] tile_index;
  logic [TILE_SHIFT-1:0] in_tile_col;
  logic [TILE_SHIFT-1:0] in_tile_row;
  logic [COLOR_W-1:0]    draw_color;
  logic                  write_enable;
  logic                  last_pixel;

  modport source (output valid, pixel_valid, tile_index, in_tile_col, in_tile_row,
                  draw_color, write_enable, last_pixel, input ready);
  modport sink (input valid, pixel_valid, tile_index, in_tile_col, in_tile_row,
                draw_color, write_enable, last_pixel, output ready);
endinterface

interface trl_cfg_if import trl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/trl_cfg_regs.sv */
// selection rectangle configuration registers
// depends on trl_pkg and trl_cfg_if
module trl_cfg_regs import trl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  trl_cfg_if.sink      cfg_chan,
  output trl_sel_cfg_t sel
);

  trl_sel_cfg_t sel_r;

  assign cfg_chan.ready = 1'b1;
  assign sel = sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r.active <= 1'b0;
      sel_r.tile_x <= '0;
      sel_r.tile_y <= '0;
      sel_r.width  <= SEL_WD_W'(1);
      sel_r.height <= SEL_HT_W'(1);
    end else if (cfg_chan.valid) begin
      // indexes past the list are dropped
      unique case (cfg_chan.index)
        REG_SEL_ACTIVE: sel_r.active <= cfg_chan.data[0];
        REG_SEL_TILE_X: sel_r.tile_x <= cfg_chan.data[SEL_TX_W-1:0];
        REG_SEL_TILE_Y: sel_r.tile_y <= cfg_chan.data[SEL_TY_W-1:0];
        REG_SEL_WIDTH:  sel_r.width  <= cfg_chan.data[SEL_WD_W-1:0];
        REG_SEL_HEIGHT: sel_r.height <= cfg_chan.data[SEL_HT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/trl_stepper.sv */
// bresenham state: endpoint load and one pixel advance per step word
// depends on trl_pkg
module trl_stepper import trl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               func,
  input  logic [X_W-1:0]     start_x,
  input  logic [Y_W-1:0]     start_y,
  input  logic [X_W-1:0]     finish_x,
  input  logic [Y_W-1:0]     finish_y,
  input  logic [COLOR_W-1:0] pen_color,
  input  logic               check_selection,
  output trl_pixel_t         pix
);

  logic               active_r, active_nxt;
  logic [X_W-1:0]     cur_x_r, cur_x_nxt, goal_x_r, goal_x_nxt, dx_r, dx_nxt;
  logic [Y_W-1:0]     cur_y_r, cur_y_nxt, goal_y_r, goal_y_nxt, dy_r, dy_nxt;
  logic               dxn_r, dxn_nxt, dyn_r, dyn_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               check_r, check_nxt;

  logic               last;
  logic [ERR_W:0]     twice, neg_dy, dx_ext, dy_ext, err_step;
  logic               x_move, y_move;
  logic [X_W-1:0]     ld_dx;
  logic [Y_W-1:0]     ld_dy;

  assign last = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);

  assign dx_ext = (ERR_W+1)'(dx_r);
  assign dy_ext = (ERR_W+1)'(dy_r);
  assign neg_dy = '0 - dy_ext;
  assign twice  = {err_r, 1'b0};
  assign x_move = $signed(twice) > $signed(neg_dy);
  assign y_move = $signed(twice) < $signed(dx_ext);
  assign err_step = {err_r[ERR_W-1], err_r} - (x_move ? dy_ext : '0)
                  + (y_move ? dx_ext : '0);

  assign ld_dx = (finish_x >= start_x) ? finish_x - start_x : start_x - finish_x;
  assign ld_dy = (finish_y >= start_y) ? finish_y - start_y : start_y - finish_y;

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dxn_nxt    = dxn_r;
    dyn_nxt    = dyn_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    check_nxt  = check_r;
    if (take && func == FUNC_LOAD) begin
      active_nxt = 1'b1;
      cur_x_nxt  = start_x;
      cur_y_nxt  = start_y;
      goal_x_nxt = finish_x;
      goal_y_nxt = finish_y;
      dx_nxt     = ld_dx;
      dy_nxt     = ld_dy;
      dxn_nxt    = !(start_x < finish_x);
      dyn_nxt    = !(start_y < finish_y);
      err_nxt    = ERR_W'(ld_dx) - ERR_W'(ld_dy);
      color_nxt  = pen_color;
      check_nxt  = check_selection;
    end else if (take && active_r) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_step[ERR_W-1:0];
        if (x_move) begin
          cur_x_nxt = dxn_r ? cur_x_r - X_W'(1) : cur_x_r + X_W'(1);
        end
        if (y_move) begin
          cur_y_nxt = dyn_r ? cur_y_r - Y_W'(1) : cur_y_r + Y_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      dxn_r    <= 1'b0;
      dyn_r    <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
      check_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      dxn_r    <= dxn_nxt;
      dyn_r    <= dyn_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
      check_r  <= check_nxt;
    end
  end

  assign pix.active = active_r;
  assign pix.last   = last;
  assign pix.x      = cur_x_r;
  assign pix.y      = cur_y_r;
  assign pix.color  = color_r;
  assign pix.check  = check_r;

endmodule

/* sv/trl_tile_map.sv */
// pixel to tile address and selection rectangle test
// depends on trl_pkg
module trl_tile_map import trl_pkg::*; #(
  parameter int TILES_ROW = TILES_ROW_DEF
) (
  input  trl_pixel_t            pix,
  input  trl_sel_cfg_t          sel,
  output logic [TILE_IDX_W-1:0] tile_index,
  output logic                  write_enable
);

  localparam int XtN = 1 << XT_W;

  logic [XT_W-1:0]        xt, tx;
  logic [YT_W-1:0]        yt;
  logic [XT_W-1:0]        tx_lut [XtN];
  logic [XT_W-1:0]        tq_lut [XtN];
  logic [TILE_FULL_W-1:0] tile_full;
  logic [YT_W:0]          ty;
  logic [SEL_WD_W:0]      x_end;
  logic [SEL_HT_W:0]      y_end;
  logic                   in_sel;

  // tile column / row of the tile number, folded per tile column
  for (genvar g = 0; g < XtN; g++) begin : g_lut
    localparam int TxVal = g % TILES_ROW;
    localparam int TqVal = g / TILES_ROW;
    assign tx_lut[g] = XT_W'(TxVal);
    assign tq_lut[g] = XT_W'(TqVal);
  end

  assign xt = pix.x[X_W-1:TILE_SHIFT];
  assign yt = pix.y[Y_W-1:TILE_SHIFT];

  assign tile_full = TILE_FULL_W'(xt)
                   + TILE_FULL_W'(yt) * TILE_FULL_W'(TILES_ROW);
  assign tile_index = tile_full[TILE_IDX_W-1:0];

  assign tx = tx_lut[xt];
  assign ty = (YT_W+1)'(yt) + (YT_W+1)'(tq_lut[xt]);

  assign x_end = (SEL_WD_W+1)'(sel.tile_x) + (SEL_WD_W+1)'(sel.width);
  assign y_end = (SEL_HT_W+1)'(sel.tile_y) + (SEL_HT_W+1)'(sel.height);

  assign in_sel = (tx >= sel.tile_x) && ((SEL_WD_W+1)'(tx) < x_end)
               && (ty >= (YT_W+1)'(sel.tile_y)) && ((SEL_HT_W+1)'(ty) < y_end);

  assign write_enable = !(pix.check && sel.active && !in_sel);

endmodule

/* sv/tile_line_rasterizer.sv */
// top level of the tile line rasterizer: channels, result register, assertions
// depends on trl_pkg, trl_ifs, trl_cfg_regs, trl_stepper, trl_tile_map
//
//   channel   dir  words
//   in_chan   in   load (endpoints, pen color, check flag) or step
//   out_chan  out  one pixel word per input word, pixel_valid 0 for load / idle step
//   cfg_chan  in   selection register writes, always ready
//
// one input word per clock while results are taken, result shown in the cycle after acceptance
// line state and the pixel address logic sit between in_chan and the result register
// in_chan is ready whenever the result register is empty or being taken
// synchronous active-low reset idles the generator and clears the selection registers, but width and height reset to 1
`include "tile_line_rasterizer_defines.svh"

module tile_line_rasterizer import trl_pkg::*; #(
  parameter int TILES_ROW = TILES_ROW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trl_in_if.sink    in_chan,
  trl_out_if.source out_chan,
  trl_cfg_if.sink   cfg_chan
);

  trl_sel_cfg_t          sel;
  trl_pixel_t            pix;
  logic [TILE_IDX_W-1:0] tile_index;
  logic                  write_enable;
  logic                  in_acc;
  logic                  emit;
  trl_result_t           res;
  trl_result_t           out_res_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  acc_load;
  logic                  out_empty_word;
  logic                  out_flags;

  // config registers
  trl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .sel      (sel)
  );

  // line generator state
  trl_stepper u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (in_acc),
    .func            (in_chan.func),
    .start_x         (in_chan.start_x),
    .start_y         (in_chan.start_y),
    .finish_x        (in_chan.finish_x),
    .finish_y        (in_chan.finish_y),
    .pen_color       (in_chan.pen_color),
    .check_selection (in_chan.check_selection),
    .pix             (pix)
  );

  // tile address and mask of the current pixel
  trl_tile_map #(
    .TILES_ROW (TILES_ROW)
  ) u_map (
    .pix          (pix),
    .sel          (sel),
    .tile_index   (tile_index),
    .write_enable (write_enable)
  );

  // accept while the result register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // a step on an armed line emits the pixel the state points at
  assign emit = (in_chan.func == FUNC_STEP) && pix.active;

  always_comb begin
    res = '0;
    if (emit) begin
      res.pixel_valid  = 1'b1;
      res.tile_index   = tile_index;
      res.in_tile_col  = pix.x[TILE_SHIFT-1:0];
      res.in_tile_row  = pix.y[TILE_SHIFT-1:0];
      res.draw_color   = pix.color;
      res.write_enable = write_enable;
      res.last_pixel   = pix.last;
    end
  end

  assign out_valid_nxt = in_acc || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_valid  = out_res_r.pixel_valid;
  assign out_chan.tile_index   = out_res_r.tile_index;
  assign out_chan.in_tile_col  = out_res_r.in_tile_col;
  assign out_chan.in_tile_row  = out_res_r.in_tile_row;
  assign out_chan.draw_color   = out_res_r.draw_color;
  assign out_chan.write_enable = out_res_r.write_enable;
  assign out_chan.last_pixel   = out_res_r.last_pixel;

  // terms for the checks below
  assign acc_load       = in_acc && in_chan.func == FUNC_LOAD;
  assign out_empty_word = out_valid_r && !out_res_r.pixel_valid;
  assign out_flags      = out_res_r.write_enable || out_res_r.last_pixel;

  // a load always arms the generator
  `TRL_ASSERT_NEXT(a_load_arms, acc_load, pix.active, "load did not arm line")
  // emitting the final pixel idles the generator
  `TRL_ASSERT_NEXT(a_last_idles, in_acc && emit && pix.last, !pix.active, "line not idled")
  // every accepted word shows up as a result word
  `TRL_ASSERT_NEXT(a_acc_result, in_acc, out_valid_r, "accepted word produced no result")
  // no result word without an accepted word
  `TRL_ASSERT_NEXT(a_no_extra, !in_acc && in_chan.ready, !out_valid_r, "result word without input")
  // a word with no pixel carries no write or last flag
  `TRL_ASSERT_NOW(a_idle_clean, out_empty_word, !out_flags, "flags set on empty result")

endmodule

/* tb/tile_line_rasterizer_checker.sv */
`timescale 1ns / 1ps
// pixel word checker for the tile line rasterizer: watches the three channels,
// predicts every pixel word and compares it field by field; depends on trl_pkg, trl_ifs
module tile_line_rasterizer_checker import trl_pkg::*; #(
  parameter int TILES_ROW = TILES_ROW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  trl_in_if    in_chan,
  trl_out_if   out_chan,
  trl_cfg_if   cfg_chan,
  output int   pending_words,
  output int   mismatch_count
);

  trl_sel_cfg_t       sel;
  logic [X_W-1:0]     pen_x, end_x, span_x;
  logic [Y_W-1:0]     pen_y, end_y, span_y;
  logic               walk_left, walk_up;
  int                 err_acc;
  logic [COLOR_W-1:0] ink;
  logic               clip_line, drawing;
  trl_result_t        pixel_queue[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns  pixel word mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // bresenham step over the tiled canvas, one word per input word
  function automatic trl_result_t rasterize_word(
    input logic               func,
    input logic [X_W-1:0]     x1,
    input logic [Y_W-1:0]     y1,
    input logic [X_W-1:0]     x2,
    input logic [Y_W-1:0]     y2,
    input logic [COLOR_W-1:0] color,
    input logic               check
  );
    trl_result_t word;
    int          tile, tcol, trow, twice;
    logic        in_sel, at_end;
    word = '0;
    if (func == FUNC_LOAD) begin
      pen_x     = x1;
      pen_y     = y1;
      end_x     = x2;
      end_y     = y2;
      span_x    = (x2 >= x1) ? x2 - x1 : x1 - x2;
      span_y    = (y2 >= y1) ? y2 - y1 : y1 - y2;
      walk_left = !(x1 < x2);
      walk_up   = !(y1 < y2);
      err_acc   = int'(span_x) - int'(span_y);
      ink       = color;
      clip_line = check;
      drawing   = 1'b1;
    end else if (drawing) begin
      tile   = int'(pen_x >> TILE_SHIFT) + int'(pen_y >> TILE_SHIFT) * TILES_ROW;
      tcol   = tile % TILES_ROW;
      trow   = tile / TILES_ROW;
      in_sel = tcol >= int'(sel.tile_x) && tcol < int'(sel.tile_x) + int'(sel.width) &&
               trow >= int'(sel.tile_y) && trow < int'(sel.tile_y) + int'(sel.height);
      at_end = (pen_x == end_x) && (pen_y == end_y);
      word.pixel_valid  = 1'b1;
      word.tile_index   = tile[TILE_IDX_W-1:0];
      word.in_tile_col  = pen_x[TILE_SHIFT-1:0];
      word.in_tile_row  = pen_y[TILE_SHIFT-1:0];
      word.draw_color   = ink;
      word.write_enable = !(clip_line && sel.active && !in_sel);
      word.last_pixel   = at_end;
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        twice = 2 * err_acc;
        if (twice > -int'(span_y)) begin
          err_acc -= int'(span_y);
          pen_x = walk_left ? pen_x - 1'b1 : pen_x + 1'b1;
        end
        if (twice < int'(span_x)) begin
          err_acc += int'(span_x);
          pen_y = walk_up ? pen_y - 1'b1 : pen_y + 1'b1;
        end
      end
    end
    return word;
  endfunction

  always @(posedge clk) begin : watch
    trl_result_t want;
    if (!rst_n) begin
      sel       = '{active: 1'b0, tile_x: '0, tile_y: '0, width: 5'd1, height: 10'd1};
      pen_x     = '0;
      pen_y     = '0;
      end_x     = '0;
      end_y     = '0;
      span_x    = '0;
      span_y    = '0;
      walk_left = 1'b0;
      walk_up   = 1'b0;
      err_acc   = 0;
      ink       = '0;
      clip_line = 1'b0;
      drawing   = 1'b0;
      pixel_queue.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_SEL_ACTIVE: sel.active = cfg_chan.data[0];
          REG_SEL_TILE_X: sel.tile_x = cfg_chan.data[SEL_TX_W-1:0];
          REG_SEL_TILE_Y: sel.tile_y = cfg_chan.data[SEL_TY_W-1:0];
          REG_SEL_WIDTH:  sel.width  = cfg_chan.data[SEL_WD_W-1:0];
          REG_SEL_HEIGHT: sel.height = cfg_chan.data[SEL_HT_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready)
        pixel_queue.push_back(rasterize_word(in_chan.func, in_chan.start_x, in_chan.start_y,
          in_chan.finish_x, in_chan.finish_y, in_chan.pen_color, in_chan.check_selection));
      if (out_chan.valid && out_chan.ready) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch("word arrived with nothing expected");
        end else begin
          want = pixel_queue.pop_front();
          check_field("pixel_valid", out_chan.pixel_valid, want.pixel_valid);
          check_field("tile_index", out_chan.tile_index, want.tile_index);
          check_field("in_tile_col", out_chan.in_tile_col, want.in_tile_col);
          check_field("in_tile_row", out_chan.in_tile_row, want.in_tile_row);
          check_field("draw_color", out_chan.draw_color, want.draw_color);
          check_field("write_enable", out_chan.write_enable, want.write_enable);
          check_field("last_pixel", out_chan.last_pixel, want.last_pixel);
        end
      end
    end
    pending_words = pixel_queue.size();
  end

endmodule

/* tb/tile_line_rasterizer_test.sv */
`timescale 1ns / 1ps
// top of the tile line rasterizer test: clock, reset, line stimulus and verdict
// depends on trl_pkg, trl_ifs, tile_line_rasterizer and tile_line_rasterizer_checker
module tile_line_rasterizer_test;
  import trl_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  trl_in_if  in_chan();
  trl_out_if out_chan();
  trl_cfg_if cfg_chan();

  int pending;
  int fails;

  // idle chances in percent, per phase
  int send_idle_pct;
  int recv_idle_pct;

  // selection as last written, used to aim lines at the rectangle edges
  int sel_x, sel_y, sel_w, sel_h;

  tile_line_rasterizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  tile_line_rasterizer_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .cfg_chan       (cfg_chan),
    .pending_words  (pending),
    .mismatch_count (fails)
  );

  always #5 clk = ~clk;

  // hard stop, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // pixel word receiver: random back-pressure, changed on the falling edge
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // one input word; called on a falling edge, returns on the falling edge after acceptance
  task automatic send_word(input logic func, input int x1, input int y1, input int x2,
                           input int y2, input int color, input int check);
    // sender gaps before the word
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.func            <= func;
    in_chan.start_x         <= x1[X_W-1:0];
    in_chan.start_y         <= y1[Y_W-1:0];
    in_chan.finish_x        <= x2[X_W-1:0];
    in_chan.finish_y        <= y2[Y_W-1:0];
    in_chan.pen_color       <= color[COLOR_W-1:0];
    in_chan.check_selection <= check[0];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // step word, the other fields are don't-care so they carry noise
  task automatic step_word();
    send_word(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // load a line, then issue a number of steps (short of the end means a restart follows)
  task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                           input int color, input int check, input int steps);
    send_word(FUNC_LOAD, x1, y1, x2, y2, color, check);
    repeat (steps) step_word();
  endtask

  // config word; valid stays high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
  endtask

  task automatic apply_selection(input int active, input int x, input int y,
                                 input int w, input int h);
    write_reg(REG_SEL_ACTIVE, active);
    write_reg(REG_SEL_TILE_X, x);
    write_reg(REG_SEL_TILE_Y, y);
    write_reg(REG_SEL_WIDTH, w);
    write_reg(REG_SEL_HEIGHT, h);
    cfg_chan.valid <= 1'b0;
    sel_x = x;
    sel_y = y;
    sel_w = w;
    sel_h = h;
  endtask

  // stop sending and wait until every expected pixel word has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // mostly well-formed lines with random content, some cut short, some with
  // trailing idle steps, and some stray words
  task automatic random_traffic(input int quota);
    int line_words, x1, y1, x2, y2, run_x, run_y, steps;
    line_words = 0;
    while (line_words < quota) begin
      if ($urandom_range(99) < 12) begin
        send_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        line_words += 1;
      end else begin
        // half the lines start around the selection rectangle so its edges get crossed
        if ($urandom_range(1)) begin
          x1 = clamp(sel_x * 8 + int'($urandom_range(sel_w * 8 + 15)) - 8, 127);
          y1 = clamp(sel_y * 8 + int'($urandom_range(sel_h * 8 + 15)) - 8, 4095);
        end else begin
          x1 = $urandom_range(127);
          y1 = $urandom_range(4095);
        end
        run_x = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(9);
        run_y = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(9);
        x2 = clamp($urandom_range(1) ? x1 + run_x : x1 - run_x, 127);
        y2 = clamp($urandom_range(1) ? y1 + run_y : y1 - run_y, 4095);
        run_x = (x2 > x1) ? x2 - x1 : x1 - x2;
        run_y = (y2 > y1) ? y2 - y1 : y1 - y2;
        steps = ((run_x > run_y) ? run_x : run_y) + 1;
        case ($urandom_range(9))
          0: steps = $urandom_range(1, steps);         // restarted mid-line
          1: steps = steps + $urandom_range(1, 3);     // steps after the end hit idle
          default: ;
        endcase
        draw_line(x1, y1, x2, y2, $urandom_range(3), $urandom_range(99) < 80, steps);
        line_words += steps + 1;
      end
    end
  endtask

  initial begin
    int seg;
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.func            = FUNC_LOAD;
    in_chan.start_x         = '0;
    in_chan.start_y         = '0;
    in_chan.finish_x        = '0;
    in_chan.finish_y        = '0;
    in_chan.pen_color       = '0;
    in_chan.check_selection = 1'b0;
    cfg_chan.valid          = 1'b0;
    cfg_chan.index          = REG_SEL_ACTIVE;
    cfg_chan.data           = '0;
    send_idle_pct           = 34;
    recv_idle_pct           = 68;
    sel_x = 0;
    sel_y = 0;
    sel_w = 1;
    sel_h = 1;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words under the reset selection
    step_word();                                   // step with no line loaded
    draw_line(0, 0, 0, 0, 3, 1, 1);                // equal endpoints, single last pixel
    draw_line(127, 4095, 0, 0, 2, 1, 3);           // far corner, walking back
    draw_line(0, 0, 127, 4095, 1, 0, 3);           // restart over an active line
    draw_line(5, 3, 1, 6, 0, 1, 6);                // full short line plus an idle step
    draw_line(60, 4000, 60, 4003, 2, 1, 4);        // vertical run inside a single tile row
    drain();

    // random phases, each under a fresh selection
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: apply_selection(1, 0, 0, 1, 1);
        1: apply_selection(1, 15, 511, 16, 512);
        2: apply_selection(1, $urandom_range(15), $urandom_range(511), 0, 1023);
        3: apply_selection(0, $urandom_range(15), $urandom_range(511), $urandom_range(31),
                           $urandom_range(1023));
        4: apply_selection(1, $urandom_range(15), $urandom_range(511), $urandom_range(1, 16),
                           $urandom_range(1, 64));
        default: apply_selection(1, $urandom_range(15), $urandom_range(511), 31, 0);
      endcase
      // idle pattern: slow receiver, then slow sender, then full rate
      send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 68 : 0;
      recv_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 34 : 0;
      random_traffic(238);
      drain();
    end

    // a result is shown in the cycle after acceptance, so the wait below leaves margin
    repeat (4) @(negedge clk);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
